// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the name and text assembler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_AT(lbl, !(cond), msg)

`endif

// ----- rtl/rnta_pkg.sv -----
// Shared types and constants of the RDS name and text assembler.
`default_nettype none

package rnta_pkg;

  localparam int unsigned NameLen       = 8;
  localparam int unsigned TextLen       = 64;
  localparam int unsigned TextRowBytes  = 4;
  localparam int unsigned TextRows      = TextLen / TextRowBytes;
  localparam int unsigned CmdQueueDepth = 2;

  localparam logic [3:0] NameTypeReset = 4'd0;
  localparam logic [3:0] TextTypeReset = 4'd2;

  // Configuration register indexes.
  localparam logic [0:0] CfgNameType = 1'b0;
  localparam logic [0:0] CfgTextType = 1'b1;

  typedef enum logic [1:0] {
    KIND_IGNORE = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_TEXT   = 2'd2
  } kind_e;

  // One classified group, as handed from the front end to the back end.
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  seg;
    logic [15:0] blk_c;
    logic [15:0] blk_d;
    logic        clear;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/rnta_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rnta_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/rnta_front.sv -----
// Front end: configuration registers and classification of incoming groups.
`default_nettype none

module rnta_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [0:0]    cfg_index_i,
  input  wire logic [3:0]    cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [15:0]   block_b_i,
  input  wire logic [15:0]   block_c_i,
  input  wire logic [15:0]   block_d_i,
  input  wire logic          station_changed_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output rnta_pkg::cmd_t     cmd_o
);

  import rnta_pkg::*;

  logic [3:0] name_type_q;
  logic [3:0] text_type_q;
  logic [3:0] gtype;
  kind_e      kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_type_q <= NameTypeReset;
      text_type_q <= TextTypeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgNameType: name_type_q <= cfg_data_i;
        CfgTextType: text_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The version bit is not part of the type code. A name match wins when
  // both registers hold the same code.
  assign gtype = block_b_i[15:12];

  always_comb begin
    if (gtype == name_type_q) begin
      kind = KIND_NAME;
    end else if (gtype == text_type_q) begin
      kind = KIND_TEXT;
    end else begin
      kind = KIND_IGNORE;
    end
  end

  assign cmd_o.kind  = kind;
  assign cmd_o.seg   = block_b_i[3:0];
  assign cmd_o.blk_c = block_c_i;
  assign cmd_o.blk_d = block_d_i;
  assign cmd_o.clear = station_changed_i;

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

`default_nettype wire

// ----- rtl/rnta_fifo.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

`include "assert_macros.svh"

module rnta_fifo #(
  parameter int unsigned Depth = rnta_pkg::CmdQueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  rnta_pkg::cmd_t      push_cmd_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output rnta_pkg::cmd_t      pop_cmd_o
);

  import rnta_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            full;
  logic            push;
  logic            pop;

  assign full         = (count_q == CntW'(Depth));
  assign push_ready_o = !full;
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_AT(a_full_ptrs_meet, full |-> (wr_ptr_q == rd_ptr_q), "queue full but pointers differ")
  `ASSERT_AT(a_empty_ptrs_meet, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "queue empty but pointers differ")

endmodule

`default_nettype wire

// ----- rtl/rnta_back.sv -----
// Back end: character stores, segment writes and character emission.
`default_nettype none

`include "assert_macros.svh"

module rnta_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  rnta_pkg::cmd_t     cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         kind_o,
  output logic [5:0]         char_index_o,
  output logic [7:0]         char_value_o,
  output logic               last_o
);

  import rnta_pkg::*;

  localparam int unsigned RowW = $clog2(TextRows);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_e;

  state_e          state_q;
  kind_e           kind_q;
  logic [5:0]      idx_q;
  logic [7:0]      name_q [NameLen];
  logic [7:0]      name_d [NameLen];
  logic [TextRows-1:0] row_vld_q;
  logic [TextRows-1:0] row_vld_d;
  logic            row_hit_q;

  logic            out_valid_q;
  logic [1:0]      out_kind_q;
  logic [5:0]      out_idx_q;
  logic [7:0]      out_val_q;
  logic            out_last_q;

  logic            pop;
  logic            slot_free;
  logic            emit;
  logic            ram_we;
  logic [31:0]     ram_rdata;
  logic [7:0]      text_byte;
  logic [7:0]      char_val;
  logic            char_last;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit        = (state_q == S_EMIT) && slot_free;
  assign ram_we      = pop && (cmd_i.kind == KIND_TEXT);

  rnta_ram #(
    .Width(8 * TextRowBytes),
    .Depth(TextRows)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_i.seg[RowW-1:0]),
    .wdata_i({cmd_i.blk_c, cmd_i.blk_d}),
    .re_i   (state_q == S_READ),
    .raddr_i(idx_q[5:2]),
    .rdata_o(ram_rdata)
  );

  // A station change empties both stores before the segment lands.
  always_comb begin
    row_vld_d = row_vld_q;
    for (int i = 0; i < NameLen; i++) begin
      name_d[i] = name_q[i];
    end
    if (pop) begin
      if (cmd_i.clear) begin
        row_vld_d = '0;
        for (int i = 0; i < NameLen; i++) begin
          name_d[i] = 8'd0;
        end
      end
      case (cmd_i.kind)
        KIND_NAME: begin
          name_d[{cmd_i.seg[1:0], 1'b0}] = cmd_i.blk_d[15:8];
          name_d[{cmd_i.seg[1:0], 1'b1}] = cmd_i.blk_d[7:0];
        end
        KIND_TEXT: row_vld_d[cmd_i.seg[RowW-1:0]] = 1'b1;
        default: ;
      endcase
    end
  end

  // Byte zero of a row is the high byte of block C.
  always_comb begin
    case (idx_q[1:0])
      2'd0:    text_byte = ram_rdata[31:24];
      2'd1:    text_byte = ram_rdata[23:16];
      2'd2:    text_byte = ram_rdata[15:8];
      default: text_byte = ram_rdata[7:0];
    endcase
  end

  always_comb begin
    case (kind_q)
      KIND_NAME: begin
        char_val  = name_q[idx_q[2:0]];
        char_last = (idx_q == 6'(NameLen - 1));
      end
      KIND_TEXT: begin
        char_val  = row_hit_q ? text_byte : 8'd0;
        char_last = (idx_q == 6'(TextLen - 1));
      end
      default: begin
        char_val  = 8'd0;
        char_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= KIND_IGNORE;
      idx_q       <= '0;
      row_vld_q   <= '0;
      row_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= '0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_last_q  <= 1'b0;
      for (int i = 0; i < NameLen; i++) begin
        name_q[i] <= 8'd0;
      end
    end else begin
      row_vld_q <= row_vld_d;
      for (int i = 0; i < NameLen; i++) begin
        name_q[i] <= name_d[i];
      end
      out_valid_q <= emit || (out_valid_q && !out_ready_i);
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            kind_q  <= cmd_i.kind;
            idx_q   <= '0;
            state_q <= (cmd_i.kind == KIND_TEXT) ? S_READ : S_EMIT;
          end
        end
        S_READ: begin
          row_hit_q <= row_vld_q[idx_q[5:2]];
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_kind_q  <= kind_q;
            out_idx_q   <= idx_q;
            out_val_q   <= char_val;
            out_last_q  <= char_last;
            if (char_last) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + 6'd1;
              if (kind_q == KIND_TEXT && idx_q[1:0] == 2'd3) begin
                state_q <= S_READ;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign char_index_o = out_idx_q;
  assign char_value_o = out_val_q;
  assign last_o       = out_last_q;

  `ASSERT_AT(a_read_then_emit, (state_q == S_READ) |=> (state_q == S_EMIT), "row read not followed by emission")
  `ASSERT_AT(a_read_row_aligned, (state_q == S_READ) |-> (idx_q[1:0] == 2'd0), "row read at unaligned index")
  `ASSERT_NEVER(a_ignore_single, out_valid_o && kind_o == KIND_IGNORE && !last_o, "ignored group result without last")

endmodule

`default_nettype wire

// ----- rtl/rds_name_text_assembler.sv -----
// Top level of the RDS program service name and radiotext assembler.
`default_nettype none

// Channel   Handshake                    Payload
// config    cfg_we_i                     cfg_index_i, cfg_data_i
// groups    in_valid_i / in_ready_o      block_b_i, block_c_i, block_d_i, station_changed_i
// chars     out_valid_o / out_ready_i    kind_o, char_index_o, char_value_o, last_o
//
// A name group first has its segment applied in the back end, then gives its eight
// characters; a text group is applied, then the text RAM gets sixteen row reads,
// each followed by four characters; an ignored group gives a single result.
// The single read port of the text RAM and the one-character output register
// set this order of steps. Reset clears the name store and the text row valid bits
// at once, so no clearing pass is needed. Groups keep being taken into the
// command queue while characters wait at the output, until the queue is full,
// and a stalled output simply holds the back end.

module rds_name_text_assembler #(
  parameter int unsigned QueueDepth = rnta_pkg::CmdQueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [0:0]    cfg_index_i,
  input  wire logic [3:0]    cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [15:0]   block_b_i,
  input  wire logic [15:0]   block_c_i,
  input  wire logic [15:0]   block_d_i,
  input  wire logic          station_changed_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         kind_o,
  output logic [5:0]         char_index_o,
  output logic [7:0]         char_value_o,
  output logic               last_o
);

  import rnta_pkg::*;

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  // The front end classifies each group by its type code as it transfers in.
  rnta_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .block_b_i        (block_b_i),
    .block_c_i        (block_c_i),
    .block_d_i        (block_d_i),
    .station_changed_i(station_changed_i),
    .cmd_valid_o      (front_valid),
    .cmd_ready_i      (front_ready),
    .cmd_o            (front_cmd)
  );

  // The queue lets the front end keep accepting while the back end emits, until it is full.
  rnta_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_cmd_i  (front_cmd),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_cmd_o   (back_cmd)
  );

  // The back end applies station changes and segments in order, then emits.
  rnta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .char_index_o(char_index_o),
    .char_value_o(char_value_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ----- verif/rds_name_text_assembler_tb.sv -----
// Self-checking testbench of the RDS program service name and radiotext assembler.
`default_nettype none

// Predicts the character stream of the assembler and checks each character transfer.
class char_scoreboard;

  typedef struct {
    rnta_pkg::kind_e kind;
    logic [5:0]      index;
    logic [7:0]      value;
    logic            last;
  } char_t;

  logic [3:0] name_type;
  logic [3:0] text_type;
  logic [7:0] name_chars[rnta_pkg::NameLen];
  logic [7:0] text_chars[rnta_pkg::TextLen];
  char_t      pending_chars[$];
  int         mismatches;

  function new();
    name_type  = rnta_pkg::NameTypeReset;
    text_type  = rnta_pkg::TextTypeReset;
    mismatches = 0;
    foreach (name_chars[i]) name_chars[i] = 8'h00;
    foreach (text_chars[i]) text_chars[i] = 8'h00;
  endfunction

  function void write_reg(logic [0:0] index, logic [3:0] value);
    case (index)
      rnta_pkg::CfgNameType: name_type = value;
      rnta_pkg::CfgTextType: text_type = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_chars.size();
  endfunction

  function void push_char(rnta_pkg::kind_e kind, int index, logic [7:0] value, logic last);
    char_t c;
    c.kind  = kind;
    c.index = index[5:0];
    c.value = value;
    c.last  = last;
    pending_chars.push_back(c);
  endfunction

  // Applies one accepted group to the stores and queues the characters it causes.
  function void note_group(logic [15:0] blk_b, logic [15:0] blk_c, logic [15:0] blk_d,
                           logic changed);
    logic [3:0] gtype;
    logic [2:0] npos;
    logic [5:0] tpos;
    gtype = blk_b[15:12];
    npos  = {blk_b[1:0], 1'b0};
    tpos  = {blk_b[3:0], 2'b00};
    if (changed) begin
      foreach (name_chars[i]) name_chars[i] = 8'h00;
      foreach (text_chars[i]) text_chars[i] = 8'h00;
    end
    if (gtype == name_type) begin
      name_chars[npos]        = blk_d[15:8];
      name_chars[npos + 3'd1] = blk_d[7:0];
      for (int i = 0; i < rnta_pkg::NameLen; i++) begin
        push_char(rnta_pkg::KIND_NAME, i, name_chars[i], i == rnta_pkg::NameLen - 1);
      end
    end else if (gtype == text_type) begin
      text_chars[tpos]        = blk_c[15:8];
      text_chars[tpos + 6'd1] = blk_c[7:0];
      text_chars[tpos + 6'd2] = blk_d[15:8];
      text_chars[tpos + 6'd3] = blk_d[7:0];
      for (int i = 0; i < rnta_pkg::TextLen; i++) begin
        push_char(rnta_pkg::KIND_TEXT, i, text_chars[i], i == rnta_pkg::TextLen - 1);
      end
    end else begin
      push_char(rnta_pkg::KIND_IGNORE, 0, 8'h00, 1'b1);
    end
  endfunction

  // Compares one character transfer with the oldest prediction.
  function void check_char(logic [1:0] kind, logic [5:0] index, logic [7:0] value,
                           logic last);
    char_t c;
    if (pending_chars.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected character kind %0d index %0d value %02h last %0d",
               $time, kind, index, value, last);
      return;
    end
    c = pending_chars.pop_front();
    if (kind != c.kind) begin
      mismatches++;
      $display("%0t: kind expected %0d actual %0d", $time, c.kind, kind);
    end
    if (index != c.index) begin
      mismatches++;
      $display("%0t: char_index expected %0d actual %0d", $time, c.index, index);
    end
    if (value != c.value) begin
      mismatches++;
      $display("%0t: char_value at %0d expected %02h actual %02h",
               $time, c.index, c.value, value);
    end
    if (last != c.last) begin
      mismatches++;
      $display("%0t: last at %0d expected %0d actual %0d", $time, c.index, c.last, last);
    end
  endfunction

endclass

module rds_name_text_assembler_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch of cycles with no transfer on either channel before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned Phases     = 8;
  localparam int unsigned PhaseItems = 19;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = rnta_pkg::CfgNameType;
  logic [3:0]  cfg_data_i = 4'h0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] block_b_i = 16'h0000;
  logic [15:0] block_c_i = 16'h0000;
  logic [15:0] block_d_i = 16'h0000;
  logic        station_changed_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [5:0]  char_index_o;
  logic [7:0]  char_value_o;
  logic        last_o;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned quiet_cycles    = 0;

  char_scoreboard board = new();

  rds_name_text_assembler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .block_b_i         (block_b_i),
    .block_c_i         (block_c_i),
    .block_d_i         (block_d_i),
    .station_changed_i (station_changed_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .char_index_o      (char_index_o),
    .char_value_o      (char_value_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  // The receiver decides its ready for the coming edge at each falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Character transfers are checked at the rising edge, where the outputs still hold
  // the values that the block presented during the cycle. The same process keeps the
  // hang watchdog: any transfer on either channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid_o && out_ready_i) begin
        board.check_char(kind_o, char_index_o, char_value_o, last_o);
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("rds_name_text_assembler_tb: FAIL");
        $finish;
      end
    end
  end

  // Offers one group and returns right after the edge at which it is transferred.
  // Valid stays high between back-to-back groups; only the payload moves on.
  task automatic send_group(input logic [15:0] blk_b, input logic [15:0] blk_c,
                            input logic [15:0] blk_d, input logic changed);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    block_b_i         <= blk_b;
    block_c_i         <= blk_c;
    block_d_i         <= blk_d;
    station_changed_i <= changed;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    board.note_group(blk_b, blk_c, blk_d, changed);
  endtask

  // Drops valid, then holds off until every predicted character has been transferred.
  task automatic wait_chars_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Writes a type register. Only called with the block idle: the stream has drained
  // and the caller waits further so the back end can settle after its last character.
  task automatic write_type_reg(input logic [0:0] index, input logic [3:0] value);
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(index, value);
  endtask

  task automatic set_group_types(input logic [3:0] name_code, input logic [3:0] text_code);
    wait_chars_done();
    repeat (4) @(posedge clk_i);
    write_type_reg(rnta_pkg::CfgNameType, name_code);
    write_type_reg(rnta_pkg::CfgTextType, text_code);
  endtask

  // Random group: mostly well-formed name and text groups under the current type
  // codes, some of arbitrary type, now and then a station change.
  function automatic void make_group(output logic [15:0] blk_b, output logic [15:0] blk_c,
                                     output logic [15:0] blk_d, output logic changed);
    int unsigned pick;
    logic [3:0]  gtype;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      gtype = board.name_type;
    end else if (pick < 8) begin
      gtype = board.text_type;
    end else begin
      gtype = 4'($urandom_range(0, 15));
    end
    blk_b = {gtype, 12'($urandom_range(0, 4095))};
    case ($urandom_range(0, 7))
      0: blk_c = 16'h0000;
      1: blk_c = 16'hFFFF;
      default: blk_c = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 7))
      0: blk_d = 16'h0000;
      1: blk_d = 16'hFFFF;
      default: blk_d = 16'($urandom_range(0, 65535));
    endcase
    changed = ($urandom_range(0, 15) == 0);
  endfunction

  logic [3:0] phase_name_type[Phases] = '{4'd0, 4'd15, 4'd0,  4'd7, 4'd3, 4'd0, 4'd15, 4'd0};
  logic [3:0] phase_text_type[Phases] = '{4'd2, 4'd0,  4'd15, 4'd7, 4'd9, 4'd2, 4'd15, 4'd0};

  initial begin
    logic [15:0] rb;
    logic [15:0] rc;
    logic [15:0] rd;
    logic        rs;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset type codes: name groups on type 0, text groups on type 2.
    // Name segments at both ends, with the version bit and the unused low bits of
    // block B set so that only B[1:0] may select the segment.
    send_group(16'h0000, 16'h1111, 16'hFFFF, 1'b0);
    send_group(16'h0003, 16'hFFFF, 16'h4142, 1'b0);
    send_group(16'h0FFE, 16'h0000, 16'hFFFF, 1'b0);
    send_group(16'h0801, 16'hFFFF, 16'h0000, 1'b0);
    // Text segments at both ends; only B[3:0] may select the row.
    send_group(16'h2000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_group(16'h200F, 16'h0000, 16'h1234, 1'b0);
    send_group(16'h2FF7, 16'hA5A5, 16'h5A5A, 1'b0);
    // Groups of other types are ignored and leave the stores alone.
    send_group(16'h1000, 16'h0000, 16'h0000, 1'b0);
    send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    // A station change wipes both stores before the group is applied, whatever its type.
    send_group(16'h2003, 16'hC3C3, 16'h3C3C, 1'b1);
    send_group(16'h0002, 16'h0000, 16'h7E7E, 1'b0);
    send_group(16'h0002, 16'h0000, 16'h6162, 1'b1);
    send_group(16'h2005, 16'h0102, 16'h0304, 1'b0);
    send_group(16'hF000, 16'hFFFF, 16'hFFFF, 1'b1);
    send_group(16'h2005, 16'h8080, 16'h0808, 1'b0);
    send_group(16'h0000, 16'h0000, 16'h0000, 1'b0);

    // Equal type codes: the group is taken as a name group.
    set_group_types(4'd5, 4'd5);
    send_group(16'h5001, 16'hDEAD, 16'hBEEF, 1'b0);
    send_group(16'h5FFF, 16'hCAFE, 16'hF00D, 1'b0);
    send_group(16'h2000, 16'h1234, 16'h5678, 1'b0);

    // Extreme codes, swapped around.
    set_group_types(4'd15, 4'd0);
    send_group(16'hF003, 16'h0000, 16'h5A5A, 1'b0);
    send_group(16'h000A, 16'hFFFF, 16'h0000, 1'b0);
    send_group(16'h2000, 16'h0000, 16'h0000, 1'b0);

    // Random part: each phase picks its type codes and one idling pattern, so every
    // pattern runs under more than one setting.
    for (int p = 0; p < Phases; p++) begin
      if (p == Phases - 1) begin
        set_group_types(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else begin
        set_group_types(phase_name_type[p], phase_text_type[p]);
      end
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 69;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 69;
        end
        default: begin
          sender_idle_pct = 9;
          recv_stall_pct  = 9;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // Once in a while the sender holds back until the stream has fully drained.
        if (n == PhaseItems / 2 && (p == 1 || p == 6)) begin
          wait_chars_done();
        end
        make_group(rb, rc, rd, rs);
        send_group(rb, rc, rd, rs);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_chars_done();
    // Leave room for any stray character after the last predicted one.
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("rds_name_text_assembler_tb: PASS");
    end else begin
      $display("rds_name_text_assembler_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
